// File: design/brbc_pkg.sv
package brbc_pkg;

    localparam int SIZE_W   = 11;
    localparam int COUNT_W  = 11;
    localparam int OFFSET_W = 10;
    localparam int INDEX_W  = 10;
    localparam int BYTE_W   = 8;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic REG_USED_SIZE = 1'b0;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_CLAIM   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_FETCH   = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode              op;
        logic [BYTE_W-1:0]    data_byte;
        logic [COUNT_W-1:0]   max_count;
        logic [INDEX_W-1:0]   fetch_index;
        logic                 fetch_oob;
    } t_job;

    typedef struct packed {
        logic              wr;
        logic [SIZE_W-1:0] value;
    } t_cfg_wr;

endpackage

// File: design/brbc_cmd_if.sv
interface brbc_cmd_if;
    import brbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic [BYTE_W-1:0]   data_byte;
    logic [COUNT_W-1:0]  max_count;
    logic [INDEX_W-1:0]  fetch_index;

    modport source (output valid, output opcode, output data_byte, output max_count,
                    output fetch_index, input ready);
    modport sink (input valid, input opcode, input data_byte, input max_count,
                  input fetch_index, output ready);
endinterface

// File: design/brbc_rsp_if.sv
interface brbc_rsp_if;
    import brbc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [OFFSET_W-1:0]  chunk_offset;
    logic [COUNT_W-1:0]   chunk_count;
    logic [BYTE_W-1:0]    fetched_byte;
    logic                 is_empty;

    modport source (output valid, output accepted, output chunk_offset, output chunk_count,
                    output fetched_byte, output is_empty, input ready);
    modport sink (input valid, input accepted, input chunk_offset, input chunk_count,
                  input fetched_byte, input is_empty, output ready);
endinterface

// File: design/brbc_front.sv
module brbc_front
    import brbc_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    brbc_cmd_if.sink  i_cmd,
    input  logic      i_q_full,
    output logic      o_push,
    output t_job      o_job
);

    assign i_cmd.ready = !i_q_full;
    assign o_push      = i_cmd.valid && !i_q_full;

    always_comb begin
        o_job.op          = t_opcode'(i_cmd.opcode);
        o_job.data_byte   = i_cmd.data_byte;
        o_job.max_count   = i_cmd.max_count;
        o_job.fetch_index = i_cmd.fetch_index;
        o_job.fetch_oob   = (32'(i_cmd.fetch_index) >= 32'(STORE_DEPTH));
    end

endmodule

// File: design/brbc_queue.sv
module brbc_queue
    import brbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_push_job,
    output logic  o_full,
    input  logic  i_pop,
    output t_job  o_pop_job,
    output logic  o_empty
);

    t_job            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_count, n_count;

    assign o_full    = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_job = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push && !o_full) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop && !o_empty) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if ((i_push && !o_full) && !(i_pop && !o_empty)) begin
            n_count = r_count + 1'b1;
        end else if (!(i_push && !o_full) && (i_pop && !o_empty)) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

// File: design/brbc_back.sv
module brbc_back
    import brbc_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg_wr            i_cfg,
    output logic [SIZE_W-1:0]  o_used_size,
    input  logic               i_q_empty,
    input  t_job               i_job,
    output logic               o_pop,
    brbc_rsp_if.source         o_rsp
);

    localparam int PW       = $clog2(STORE_DEPTH);
    localparam int CW       = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
    localparam int RST_SIZE = (STORE_DEPTH < 1024) ? STORE_DEPTH : 1024;

    logic [BYTE_W-1:0]   r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]   r_rd_byte;

    logic [PW-1:0]       r_wp, n_wp;
    logic [PW-1:0]       r_rp, n_rp;
    logic [PW-1:0]       r_relp, n_relp;
    logic [SIZE_W-1:0]   r_size, n_size;

    logic                r_out_valid, n_out_valid;
    logic                r_accepted, n_accepted;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_fetch_sel, n_fetch_sel;
    logic                r_is_empty, n_is_empty;

    logic                adv;
    logic                wr_ok;
    logic                mem_we;
    logic                mem_re;
    logic [PW-1:0]       rd_addr;
    logic [CW-1:0]       wp_c, rp_c, sz_c, mc_c, nx_c, avail;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v < SIZE_W'(2)) begin
            res = SIZE_W'(2);
        end else if (CW'(v) > CW'(STORE_DEPTH)) begin
            res = SIZE_W'(STORE_DEPTH);
        end
        return res;
    endfunction

    assign adv     = !i_q_empty && (!r_out_valid || o_rsp.ready);
    assign o_pop   = adv;
    assign wp_c    = CW'(r_wp);
    assign rp_c    = CW'(r_rp);
    assign sz_c    = CW'(r_size);
    assign mc_c    = CW'(i_job.max_count);
    assign nx_c    = ((wp_c + 1'b1) >= sz_c) ? '0 : (wp_c + 1'b1);
    assign wr_ok   = (nx_c != CW'(r_relp));
    assign mem_we  = adv && (i_job.op == OP_WRITE) && wr_ok;
    assign mem_re  = adv && (i_job.op == OP_FETCH) && !i_job.fetch_oob;
    assign rd_addr = PW'(i_job.fetch_index);

    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_relp      = r_relp;
        n_size      = r_size;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_accepted  = r_accepted;
        n_offset    = r_offset;
        n_count     = r_count;
        n_fetch_sel = r_fetch_sel;
        n_is_empty  = r_is_empty;
        avail       = '0;

        if (i_cfg.wr) begin
            n_size = clamp_size(i_cfg.value);
            n_wp   = '0;
            n_rp   = '0;
            n_relp = '0;
        end else if (adv) begin
            n_out_valid = 1'b1;
            n_accepted  = 1'b0;
            n_offset    = '0;
            n_count     = '0;
            n_fetch_sel = 1'b0;
            case (i_job.op)
                OP_WRITE: begin
                    if (wr_ok) begin
                        n_wp       = PW'(nx_c);
                        n_accepted = 1'b1;
                    end
                end
                OP_CLAIM: begin
                    n_relp   = r_rp;
                    n_offset = OFFSET_W'(r_rp);
                    if (wp_c > rp_c) begin
                        avail = wp_c - rp_c;
                        if (avail > mc_c) begin
                            n_count = i_job.max_count;
                            n_rp    = PW'(rp_c + mc_c);
                        end else begin
                            n_count = COUNT_W'(avail);
                            n_rp    = r_wp;
                        end
                    end else if (wp_c < rp_c) begin
                        avail = sz_c - rp_c;
                        if (avail > mc_c) begin
                            n_count = i_job.max_count;
                            n_rp    = PW'(rp_c + mc_c);
                        end else begin
                            n_count = COUNT_W'(avail);
                            n_rp    = '0;
                        end
                    end
                end
                OP_RELEASE: begin
                    n_relp = r_rp;
                end
                OP_FETCH: begin
                    n_fetch_sel = !i_job.fetch_oob;
                end
                default: begin
                    n_fetch_sel = 1'b0;
                end
            endcase
            n_is_empty = (n_rp == n_wp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_relp      <= '0;
            r_size      <= SIZE_W'(RST_SIZE);
            r_out_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_relp      <= n_relp;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
        r_accepted  <= n_accepted;
        r_offset    <= n_offset;
        r_count     <= n_count;
        r_fetch_sel <= n_fetch_sel;
        r_is_empty  <= n_is_empty;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= i_job.data_byte;
        end
        if (mem_re) begin
            r_rd_byte <= r_mem[rd_addr];
        end
    end

    assign o_used_size        = r_size;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.accepted     = r_accepted;
    assign o_rsp.chunk_offset = r_offset;
    assign o_rsp.chunk_count  = r_count;
    assign o_rsp.fetched_byte = r_fetch_sel ? r_rd_byte : '0;
    assign o_rsp.is_empty     = r_is_empty;

`ifndef SYNTH
    a_wp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_wp) < CW'(r_size))
        else $error("write pointer outside ring");
    a_rp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_rp) < CW'(r_size) && CW'(r_relp) < CW'(r_size))
        else $error("read or release pointer outside ring");
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size >= SIZE_W'(2) && CW'(r_size) <= CW'(STORE_DEPTH))
        else $error("ring size out of range");
    a_write_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && !i_cfg.wr) |=> (r_wp != $past(r_wp)) && r_out_valid && r_accepted)
        else $error("stored word did not advance write pointer");
`endif

endmodule

// File: design/byte_ring_buffer_claim_release_core.sv
// Channel  Dir  Handshake      Word
// i_cmd    in   valid/ready    opcode, data_byte, max_count, fetch_index
// o_rsp    out  valid/ready    accepted, chunk_offset, chunk_count, fetched_byte, is_empty
// apb      in   psel/penable   used_size at byte address 0, pready tied high
//
// One word per cycle sustained while o_rsp is ready; a command passes through the queue and
// then the result register, which loads in step with the byte store's read port.
// Reset clears the pointers, the queue and the result valid flag; the result fields and the store are not cleared.
// A stalled o_rsp holds its word while i_cmd keeps filling the four-entry queue.
// A used_size write empties the ring.
module byte_ring_buffer_claim_release_core
    import brbc_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    brbc_cmd_if.sink           i_cmd,
    brbc_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    t_cfg_wr            cfg;
    logic [SIZE_W-1:0]  used_size;
    logic               q_full;
    logic               q_empty;
    logic               push;
    logic               pop;
    t_job               push_job;
    t_job               pop_job;

    assign pready    = 1'b1;
    assign cfg.wr    = psel && penable && pwrite && (paddr[2] == REG_USED_SIZE);
    assign cfg.value = pwdata[SIZE_W-1:0];
    assign prdata    = (paddr[2] == REG_USED_SIZE) ? APB_DW'(used_size) : '0;

    brbc_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    brbc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_pop_job  (pop_job),
        .o_empty    (q_empty)
    );

    brbc_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .o_used_size (used_size),
        .i_q_empty   (q_empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_rsp       (o_rsp)
    );

endmodule

// File: tb/tb_top.sv
module tb_top;
    import brbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 1024;
    localparam int REG_STRIDE  = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 6;

    typedef struct packed {
        logic                accepted;
        logic [OFFSET_W-1:0] chunk_offset;
        logic [COUNT_W-1:0]  chunk_count;
        logic [BYTE_W-1:0]   fetched_byte;
        logic                is_empty;
    } t_rsp_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    brbc_cmd_if cmd_bus ();
    brbc_rsp_if rsp_bus ();

    byte_ring_buffer_claim_release_core #(
        .STORE_DEPTH (STORE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ring model
    logic [BYTE_W-1:0] ring_store [0:STORE_DEPTH-1];
    bit                slot_written [0:STORE_DEPTH-1];
    int                written_list [$];
    int                ring_size = STORE_DEPTH;
    int                wr_ptr = 0;
    int                rd_ptr = 0;
    int                rel_ptr = 0;

    t_rsp_word expected_words [$];

    bit calm = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int words_sent = 0;
    int words_checked = 0;
    int size_settings = 0;

    initial begin
        cmd_bus.valid       = 1'b0;
        cmd_bus.opcode      = OP_WRITE;
        cmd_bus.data_byte   = '0;
        cmd_bus.max_count   = '0;
        cmd_bus.fetch_index = '0;
        rsp_bus.ready       = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: watchdog expired, %0d words still expected",
                     $time, expected_words.size());
            $display("byte_ring_buffer_claim_release_core test failed");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (calm) begin
            rsp_bus.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    function automatic int next_slot(int p);
        return (p + 1 >= ring_size) ? 0 : p + 1;
    endfunction

    function automatic t_rsp_word predict_ring_word(t_opcode op, logic [BYTE_W-1:0] d,
                                                    logic [COUNT_W-1:0] mc,
                                                    logic [INDEX_W-1:0] fi);
        t_rsp_word w;
        int        nx;
        int        avail;
        w = '0;
        case (op)
            OP_WRITE: begin
                nx = next_slot(wr_ptr);
                if (nx != rel_ptr) begin
                    ring_store[wr_ptr] = d;
                    if (!slot_written[wr_ptr]) begin
                        slot_written[wr_ptr] = 1'b1;
                        written_list.push_back(wr_ptr);
                    end
                    wr_ptr = nx;
                    w.accepted = 1'b1;
                end
            end
            OP_CLAIM: begin
                rel_ptr = rd_ptr;
                w.chunk_offset = OFFSET_W'(rd_ptr);
                if (wr_ptr > rd_ptr) begin
                    avail = wr_ptr - rd_ptr;
                    if (avail > int'(mc)) begin
                        w.chunk_count = mc;
                        rd_ptr += int'(mc);
                    end else begin
                        w.chunk_count = COUNT_W'(avail);
                        rd_ptr = wr_ptr;
                    end
                end else if (wr_ptr < rd_ptr) begin
                    avail = ring_size - rd_ptr;
                    if (avail > int'(mc)) begin
                        w.chunk_count = mc;
                        rd_ptr += int'(mc);
                    end else begin
                        w.chunk_count = COUNT_W'(avail);
                        rd_ptr = 0;
                    end
                end
            end
            OP_RELEASE: begin
                rel_ptr = rd_ptr;
            end
            default: begin
                w.fetched_byte = ring_store[fi];
            end
        endcase
        w.is_empty = (rd_ptr == wr_ptr);
        return w;
    endfunction

    task automatic report_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp_word exp_w;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none actual %0h",
                         $time, {rsp_bus.accepted, rsp_bus.chunk_offset, rsp_bus.chunk_count,
                                 rsp_bus.fetched_byte, rsp_bus.is_empty});
                fail_count++;
            end else begin
                exp_w = expected_words.pop_front();
                report_field("accepted", 32'(exp_w.accepted), 32'(rsp_bus.accepted));
                report_field("chunk_offset", 32'(exp_w.chunk_offset),
                             32'(rsp_bus.chunk_offset));
                report_field("chunk_count", 32'(exp_w.chunk_count), 32'(rsp_bus.chunk_count));
                report_field("fetched_byte", 32'(exp_w.fetched_byte),
                             32'(rsp_bus.fetched_byte));
                report_field("is_empty", 32'(exp_w.is_empty), 32'(rsp_bus.is_empty));
                words_checked++;
            end
        end
    end

    task automatic send_word(t_opcode op, logic [BYTE_W-1:0] d, logic [COUNT_W-1:0] mc,
                             logic [INDEX_W-1:0] fi);
        int gap;
        @(negedge i_clk);
        cmd_bus.valid       <= 1'b1;
        cmd_bus.opcode      <= op;
        cmd_bus.data_byte   <= d;
        cmd_bus.max_count   <= mc;
        cmd_bus.fetch_index <= fi;
        do @(posedge i_clk); while (!cmd_bus.ready);
        expected_words.push_back(predict_ring_word(op, d, mc, fi));
        words_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            cmd_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_ring_words();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_used_size(logic [SIZE_W-1:0] value);
        drain_ring_words();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'(REG_STRIDE * REG_USED_SIZE);
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (value < 2) ring_size = 2;
        else if (value > STORE_DEPTH) ring_size = STORE_DEPTH;
        else ring_size = int'(value);
        wr_ptr  = 0;
        rd_ptr  = 0;
        rel_ptr = 0;
        size_settings++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_word(int write_pct);
        int                 roll;
        int                 fi;
        t_opcode            op;
        logic [BYTE_W-1:0]  d;
        logic [COUNT_W-1:0] mc;
        roll = $urandom_range(0, 99);
        fi = $urandom_range(0, STORE_DEPTH - 1);
        if (!slot_written[fi] && written_list.size() > 0)
            fi = written_list[$urandom_range(0, written_list.size() - 1)];
        if (roll < write_pct) op = OP_WRITE;
        else if (roll < write_pct + (100 - write_pct) / 2) op = OP_CLAIM;
        else if (roll < write_pct + 3 * (100 - write_pct) / 4) op = OP_RELEASE;
        else op = OP_FETCH;
        if (op == OP_FETCH && !slot_written[fi]) op = OP_CLAIM;
        d = BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: mc = '0;
            1: mc = COUNT_W'(STORE_DEPTH);
            2, 3: mc = COUNT_W'($urandom_range(1, 8));
            default: mc = COUNT_W'($urandom_range(0, STORE_DEPTH));
        endcase
        send_word(op, d, mc, INDEX_W'(fi));
    endtask

    task automatic test_reset_state();
        send_word(OP_CLAIM, 8'h00, 11'd1024, 10'd0);
        send_word(OP_CLAIM, 8'h00, 11'd0, 10'd0);
        send_word(OP_RELEASE, 8'h00, 11'd0, 10'd0);
        send_word(OP_WRITE, 8'h00, 11'd0, 10'd0);
        send_word(OP_WRITE, 8'hFF, 11'd0, 10'd0);
        send_word(OP_FETCH, 8'h00, 11'd0, 10'd0);
        send_word(OP_FETCH, 8'h00, 11'd0, 10'd1);
        send_word(OP_CLAIM, 8'h00, 11'd0, 10'd0);
        send_word(OP_CLAIM, 8'h00, 11'd1, 10'd0);
        send_word(OP_CLAIM, 8'h00, 11'd1024, 10'd0);
        send_word(OP_RELEASE, 8'h00, 11'd0, 10'd0);
        send_word(OP_FETCH, 8'h00, 11'd0, 10'd1);
    endtask

    task automatic test_size_limits();
        write_used_size(11'd0);
        send_word(OP_WRITE, 8'hA5, 11'd0, 10'd0);
        send_word(OP_WRITE, 8'h5A, 11'd0, 10'd0);
        send_word(OP_CLAIM, 8'h00, 11'd1024, 10'd0);
        send_word(OP_WRITE, 8'h3C, 11'd0, 10'd0);
        send_word(OP_RELEASE, 8'h00, 11'd0, 10'd0);
        send_word(OP_WRITE, 8'hC3, 11'd0, 10'd0);
        send_word(OP_CLAIM, 8'h00, 11'd1024, 10'd0);
        send_word(OP_FETCH, 8'h00, 11'd0, 10'd1);
        write_used_size(11'd1);
        send_word(OP_WRITE, 8'h81, 11'd0, 10'd0);
        send_word(OP_WRITE, 8'h18, 11'd0, 10'd0);
        write_used_size(11'd2047);
        send_word(OP_CLAIM, 8'h00, 11'd2, 10'd0);
        send_word(OP_WRITE, 8'h7E, 11'd0, 10'd0);
        write_used_size(11'd1025);
        send_word(OP_WRITE, 8'hE7, 11'd0, 10'd0);
        send_word(OP_FETCH, 8'h00, 11'd0, 10'd1);
    endtask

    // run the write pointer past the top slot of a full-size ring
    task automatic test_full_size_wrap();
        write_used_size(11'd1024);
        while (!slot_written[STORE_DEPTH - 1]) send_random_word(85);
        repeat (100) send_random_word(30);
    endtask

    task automatic test_random_sizes();
        logic [SIZE_W-1:0] sizes [10];
        sizes = '{11'd5, 11'd2, 11'd3, 11'd1024, 11'd0, 11'd1, 11'd1025, 11'd2047,
                  11'd17, 11'd64};
        for (int i = 0; i < 10; i++) begin
            write_used_size(sizes[i]);
            repeat (35) send_random_word((i % 2 == 0) ? 75 : 40);
        end
        write_used_size(SIZE_W'($urandom_range(2, 32)));
        repeat (35) send_random_word(60);
    endtask

    task automatic test_no_idle_tail();
        write_used_size(SIZE_W'($urandom_range(2, 32)));
        calm = 1'b1;
        repeat (100) send_random_word(60);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_size_limits();
        test_full_size_wrap();
        test_random_sizes();
        test_no_idle_tail();
        drain_ring_words();
        $display("ran %0d command words over %0d ring size settings, %0d results checked",
                 words_sent, size_settings, words_checked);
        if (fail_count == 0) begin
            $display("byte_ring_buffer_claim_release_core test passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("byte_ring_buffer_claim_release_core test failed");
        end
        $finish;
    end

endmodule
